// ----- sv/cbd_pkg.sv -----
// Shared types, constants and the LED drive table of the charlieplexed bar/dot display.
package cbd_pkg;

  localparam int unsigned FrameLength = 20;
  localparam int unsigned LedCount    = 20;

  localparam int unsigned LevelW = 8;
  localparam int unsigned CountW = 5;
  localparam int unsigned LedW   = 5;
  localparam int unsigned LinesW = 5;

  localparam logic [CountW-1:0] FrameReload = CountW'(FrameLength);

  // Line masks, bit0 = line 3.
  localparam logic [LinesW-1:0] L3 = 5'h01;
  localparam logic [LinesW-1:0] L4 = 5'h02;
  localparam logic [LinesW-1:0] L5 = 5'h04;
  localparam logic [LinesW-1:0] L6 = 5'h08;
  localparam logic [LinesW-1:0] L7 = 5'h10;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_SET_PEAK  = 2'd1,
    OP_SET_POWER = 2'd2,
    OP_SET_MODE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_DOT  = 2'd1,
    MODE_BAR  = 2'd2,
    MODE_BAD  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [LinesW-1:0] enable;
    logic [LinesW-1:0] high;
  } lines_t;

  // Direction and drive masks for one LED; index 0 and anything past the bar is all off.
  function automatic lines_t led_lines(logic [LedW-1:0] led);
    lines_t r;
    r = '0;
    unique case (led)
      5'd1:  r = '{enable: L3 | L7, high: L3};
      5'd2:  r = '{enable: L3 | L7, high: L7};
      5'd3:  r = '{enable: L3 | L6, high: L3};
      5'd4:  r = '{enable: L3 | L6, high: L6};
      5'd5:  r = '{enable: L4 | L7, high: L4};
      5'd6:  r = '{enable: L4 | L7, high: L7};
      5'd7:  r = '{enable: L4 | L6, high: L4};
      5'd8:  r = '{enable: L4 | L6, high: L6};
      5'd9:  r = '{enable: L5 | L7, high: L5};
      5'd10: r = '{enable: L5 | L7, high: L7};
      5'd11: r = '{enable: L3 | L5, high: L3};
      5'd12: r = '{enable: L3 | L5, high: L5};
      5'd13: r = '{enable: L6 | L7, high: L6};
      5'd14: r = '{enable: L6 | L7, high: L7};
      5'd15: r = '{enable: L5 | L6, high: L5};
      5'd16: r = '{enable: L5 | L6, high: L6};
      5'd17: r = '{enable: L4 | L5, high: L4};
      5'd18: r = '{enable: L4 | L5, high: L5};
      5'd19: r = '{enable: L3 | L4, high: L3};
      5'd20: r = '{enable: L3 | L4, high: L4};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/charlieplex_bar_dot_display.sv -----
// Top level of the charlieplexed 20-LED bar/dot display driver.

// Takes one transaction per clock while in_stall_o is low: ticks, peak-level writes,
// power-level writes and mode sets. Each accepted transaction updates the mode, duty
// count and level registers it touches in the cycle it is accepted; a tick in dot or
// bar mode also yields one result (LED index plus line-enable and line-high masks for
// lines 3..7), which goes to the output port through the output register. A
// one-entry skid register sits behind the output register, so input keeps flowing
// at one transaction per cycle while a single result waits; in_stall_o rises only
// when both are full. Level writes, mode sets and idle-mode ticks yield no result,
// nor does a bad-mode tick, which returns the mode to idle. A mode set restarts
// the duty count at the frame length and latches the shown level (peak level in dot
// mode, power level otherwise); the count wraps after reaching one and relatches.
module charlieplex_bar_dot_display (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                operation_i,
  input  logic [cbd_pkg::LevelW-1:0] value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [cbd_pkg::LedW-1:0]   led_index_o,
  output logic [cbd_pkg::LinesW-1:0] line_enable_o,
  output logic [cbd_pkg::LinesW-1:0] line_high_o
);

  typedef struct packed {
    logic [cbd_pkg::LedW-1:0] led;
    cbd_pkg::lines_t          lines;
  } result_t;

  // Display state
  cbd_pkg::mode_e              mode_q, mode_d;
  logic [cbd_pkg::CountW-1:0]  count_q, count_d;
  logic [cbd_pkg::LevelW-1:0]  peak_q, peak_d;
  logic [cbd_pkg::LevelW-1:0]  power_q, power_d;
  logic [cbd_pkg::LevelW-1:0]  shown_q, shown_d;

  // Output register and skid stage
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;
  logic    skid_valid_q, skid_valid_d;
  result_t skid_q, skid_d;

  logic                        in_accept;
  logic                        out_take;
  logic                        res_valid;
  result_t                     res;
  logic [cbd_pkg::LedW-1:0]    led;
  logic [cbd_pkg::LevelW-1:0]  count_ext;
  cbd_pkg::op_e                op;

  assign op        = cbd_pkg::op_e'(operation_i);
  assign in_stall_o = skid_valid_q;
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_take  = out_valid_q && !out_stall_i;
  assign count_ext = cbd_pkg::LevelW'(count_q);

  // Pick the lit LED for a tick; all off when no count matches.
  always_comb begin
    led = '0;
    if (mode_q == cbd_pkg::MODE_DOT) begin
      if (count_ext == shown_q) led = count_q;
    end else begin
      if (count_ext <= shown_q) led = count_q;
    end
  end

  assign res.led   = led;
  assign res.lines = cbd_pkg::led_lines(led);

  // State update for one accepted transaction.
  always_comb begin
    mode_d    = mode_q;
    count_d   = count_q;
    peak_d    = peak_q;
    power_d   = power_q;
    shown_d   = shown_q;
    res_valid = 1'b0;
    if (in_accept) begin
      case (op)
        cbd_pkg::OP_SET_PEAK:  peak_d = value_i;
        cbd_pkg::OP_SET_POWER: power_d = value_i;
        cbd_pkg::OP_SET_MODE: begin
          if (value_i > cbd_pkg::LevelW'(cbd_pkg::MODE_BAR)) mode_d = cbd_pkg::MODE_BAD;
          else mode_d = cbd_pkg::mode_e'(value_i[1:0]);
          count_d = cbd_pkg::FrameReload;
          shown_d = (mode_d == cbd_pkg::MODE_DOT) ? peak_q : power_q;
        end
        default: begin
          // Tick
          case (mode_q)
            cbd_pkg::MODE_IDLE: ;
            cbd_pkg::MODE_BAD:  mode_d = cbd_pkg::MODE_IDLE;
            default: begin
              res_valid = 1'b1;
              if (count_q <= cbd_pkg::CountW'(1)) begin
                count_d = cbd_pkg::FrameReload;
                shown_d = (mode_q == cbd_pkg::MODE_DOT) ? peak_q : power_q;
              end else begin
                count_d = count_q - cbd_pkg::CountW'(1);
              end
            end
          endcase
        end
      endcase
    end
  end

  // Fill the output register from skid first, else take a new result or park it in skid.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || out_take) begin
      out_valid_d = res_valid;
      if (res_valid) out_d = res;
    end else if (res_valid) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= cbd_pkg::MODE_IDLE;
      count_q      <= cbd_pkg::FrameReload;
      peak_q       <= '0;
      power_q      <= '0;
      shown_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      count_q      <= count_d;
      peak_q       <= peak_d;
      power_q      <= power_d;
      shown_q      <= shown_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o   = out_valid_q;
  assign led_index_o   = out_q.led;
  assign line_enable_o = out_q.lines.enable;
  assign line_high_o   = out_q.lines.high;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a result while the output register is empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (count_q <= cbd_pkg::FrameReload))
    else $error("duty count out of range");

  a_dark_is_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (led_index_o == '0)) |-> ((line_enable_o == '0) && (line_high_o == '0)))
    else $error("lines driven with no LED selected");

  a_idle_tick_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (op == cbd_pkg::OP_TICK) && (mode_q == cbd_pkg::MODE_IDLE))
      |=> ($stable(count_q) && $stable(shown_q) && (mode_q == cbd_pkg::MODE_IDLE)))
    else $error("idle tick changed display state");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !out_valid_q) |=> out_valid_q)
    else $error("tick result lost");
`endif

endmodule

// ----- verif/display_result_checker.sv -----
// Checker: predicts the lit LED for each accepted tick in dot or bar mode and compares every result.
`timescale 1ns / 100ps

module display_result_checker
  import cbd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [1:0]          operation_i,
  input  logic [LevelW-1:0]   value_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [LedW-1:0]     led_index_i,
  input  logic [LinesW-1:0]   line_enable_i,
  input  logic [LinesW-1:0]   line_high_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [LedW-1:0]   led;
    logic [LinesW-1:0] enable;
    logic [LinesW-1:0] high;
  } led_drive_t;

  led_drive_t               lit_queue[$];
  mode_e                    mode;
  logic [CountW-1:0]        count;
  logic [LevelW-1:0]        peak;
  logic [LevelW-1:0]        power;
  logic [LevelW-1:0]        shown;
  int                       fails = 0;

  // LEDs come in pairs that share two lines; the odd one drives the first line high.
  function automatic led_drive_t drive_for(input logic [LedW-1:0] led);
    logic [LinesW-1:0] first;
    logic [LinesW-1:0] second;
    logic [3:0]        pair;
    led_drive_t        d;
    d = '0;
    if (led >= 1 && led <= LedCount) begin
      pair = 4'((led - 5'd1) >> 1);
      case (pair)
        4'd0:    begin first = L3; second = L7; end
        4'd1:    begin first = L3; second = L6; end
        4'd2:    begin first = L4; second = L7; end
        4'd3:    begin first = L4; second = L6; end
        4'd4:    begin first = L5; second = L7; end
        4'd5:    begin first = L3; second = L5; end
        4'd6:    begin first = L6; second = L7; end
        4'd7:    begin first = L5; second = L6; end
        4'd8:    begin first = L4; second = L5; end
        default: begin first = L3; second = L4; end
      endcase
      d.led    = led;
      d.enable = first | second;
      d.high   = led[0] ? first : second;
    end
    return d;
  endfunction

  task automatic apply_transaction(input op_e op, input logic [LevelW-1:0] val);
    logic [LedW-1:0] led;
    case (op)
      OP_SET_PEAK:  peak = val;
      OP_SET_POWER: power = val;
      OP_SET_MODE: begin
        mode  = (val <= LevelW'(MODE_BAR)) ? mode_e'(val[1:0]) : MODE_BAD;
        count = FrameReload;
        shown = (mode == MODE_DOT) ? peak : power;
      end
      default: begin
        if (mode == MODE_BAD) begin
          mode = MODE_IDLE;
        end else if (mode != MODE_IDLE) begin
          if (mode == MODE_DOT) begin
            led = (LevelW'(count) == shown) ? shown[LedW-1:0] : '0;
          end else begin
            led = (LevelW'(count) <= shown) ? count : '0;
          end
          lit_queue.push_back(drive_for(led));
          // wrap after one: reload and relatch the shown level
          if (count <= 1) begin
            count = FrameReload;
            shown = (mode == MODE_DOT) ? peak : power;
          end else begin
            count = count - 1'b1;
          end
        end
      end
    endcase
  endtask

  function automatic int field_error(input string name, input logic [4:0] want,
                                     input logic [4:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    led_drive_t want;
    if (!rst_ni) begin
      mode  = MODE_IDLE;
      count = FrameReload;
      peak  = '0;
      power = '0;
      shown = '0;
      lit_queue.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (lit_queue.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual led %0d en %0h hi %0h",
                   $time, led_index_i, line_enable_i, line_high_i);
          fails++;
        end else begin
          want = lit_queue.pop_front();
          fails += field_error("led_index", want.led, led_index_i);
          fails += field_error("line_enable", want.enable, line_enable_i);
          fails += field_error("line_high", want.high, line_high_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_transaction(op_e'(operation_i), value_i);
      end
    end
    fail_count_o <= fails;
    pending_o    <= lit_queue.size();
  end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top: drives display transactions with random idling and gives the verdict.
`timescale 1ns / 100ps

module tb_top;
  import cbd_pkg::*;

  localparam int ItemTarget  = 800;
  // Longest quiet stretch in a correct run is a sender gap plus a receiver stall;
  // the limit allows far more.
  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 8;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  op_e                 operation = OP_TICK;
  logic [LevelW-1:0]   value     = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [LedW-1:0]     led_index;
  logic [LinesW-1:0]   line_enable;
  logic [LinesW-1:0]   line_high;
  int                  fail_count;
  int                  pending_results;

  // Sender bookkeeping: burst length left, and a coarse mode shadow that only
  // serves to skip ticks the block ignores when counting stimulus.
  int                  burst_left   = 0;
  int                  driven_items = 0;
  mode_e               drive_mode   = MODE_IDLE;

  // Receiver stall pattern state.
  int                  stall_style = 0;
  int                  stall_left  = 0;
  int                  stall_phase = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  charlieplex_bar_dot_display i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .operation_i  (operation),
    .value_i      (value),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .led_index_o  (led_index),
    .line_enable_o(line_enable),
    .line_high_o  (line_high)
  );

  display_result_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .operation_i  (operation),
    .value_i      (value),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .led_index_i  (led_index),
    .line_enable_i(line_enable),
    .line_high_i  (line_high),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  // Receiver: pick a stall style for a random stretch of cycles. Styles cover
  // no stall at all, coin-flip stalls, rare stalls and a regular on/off pattern
  // long enough to back results up into the skid register and stall the input.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_style = $urandom_range(0, 3);
        stall_left  = $urandom_range(10, 150);
        stall_phase = 0;
      end
      stall_left--;
      stall_phase++;
      case (stall_style)
        0:       out_stall <= 1'b0;
        1:       out_stall <= 1'($urandom_range(0, 1));
        2:       out_stall <= ($urandom_range(0, 7) == 0);
        default: out_stall <= ((stall_phase % 24) < 12);
      endcase
    end
  end

  // Present one transaction, hold it until accepted, then either continue the
  // burst back to back or drop valid for a random gap.
  task automatic send_item(input op_e op, input logic [LevelW-1:0] val);
    int gap;
    in_valid  <= 1'b1;
    operation <= op;
    value     <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);

    case (op)
      OP_SET_MODE: begin
        drive_mode = (val <= LevelW'(MODE_BAR)) ? mode_e'(val[1:0]) : MODE_BAD;
        driven_items++;
      end
      OP_TICK: begin
        if (drive_mode != MODE_IDLE) driven_items++;
        if (drive_mode == MODE_BAD) drive_mode = MODE_IDLE;
      end
      default: driven_items++;
    endcase

    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Levels mostly sit around the frame so dots and bars actually light; some
  // span the full byte to reach the above-frame cases and every value bit.
  function automatic logic [LevelW-1:0] random_level();
    return ($urandom_range(0, 9) < 7) ? LevelW'($urandom_range(0, 21))
                                      : LevelW'($urandom_range(0, 255));
  endfunction

  // Watchdog: end the run if no transaction moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int ticks;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle tick, extreme levels, dot at the top of the frame, bar with
    // a level above the frame, invalid modes decaying to idle, an all-off bar,
    // and a dot level above the frame.
    send_item(OP_TICK, 8'd0);
    send_item(OP_SET_PEAK, 8'd20);
    send_item(OP_SET_POWER, 8'd255);
    send_item(OP_SET_MODE, LevelW'(MODE_DOT));
    send_item(OP_TICK, 8'd0);
    send_item(OP_TICK, 8'd255);
    send_item(OP_SET_MODE, LevelW'(MODE_BAR));
    send_item(OP_TICK, 8'd0);
    send_item(OP_TICK, 8'd0);
    send_item(OP_SET_MODE, LevelW'(MODE_BAD));
    send_item(OP_TICK, 8'd0);
    send_item(OP_TICK, 8'd0);
    send_item(OP_SET_MODE, 8'd255);
    send_item(OP_TICK, 8'd0);
    send_item(OP_SET_MODE, LevelW'(MODE_IDLE));
    send_item(OP_SET_POWER, 8'd0);
    send_item(OP_SET_MODE, LevelW'(MODE_BAR));
    send_item(OP_TICK, 8'd0);
    send_item(OP_SET_PEAK, 8'd255);
    send_item(OP_SET_MODE, LevelW'(MODE_DOT));
    send_item(OP_TICK, 8'd0);
    send_item(OP_SET_POWER, 8'hAA);
    send_item(OP_SET_PEAK, 8'h55);
    send_item(OP_TICK, 8'd0);

    // Random: mostly well-formed frames (levels, a mode, then a run of ticks that
    // may cross wraps, with level writes landing mid-frame), plus noise with random
    // operations and mode values that are mostly invalid.
    while (driven_items < ItemTarget) begin
      if ($urandom_range(0, 9) < 8) begin
        send_item(OP_SET_PEAK, random_level());
        send_item(OP_SET_POWER, random_level());
        send_item(OP_SET_MODE, $urandom_range(0, 1) ? LevelW'(MODE_DOT) : LevelW'(MODE_BAR));
        ticks = $urandom_range(5, 45);
        repeat (ticks) begin
          if ($urandom_range(0, 9) == 0) begin
            send_item($urandom_range(0, 1) ? OP_SET_PEAK : OP_SET_POWER, random_level());
          end
          send_item(OP_TICK, LevelW'($urandom()));
        end
      end else begin
        repeat ($urandom_range(1, 6)) send_item(op_e'($urandom_range(0, 3)), LevelW'($urandom()));
      end
    end

    // Drain: drop valid, let the checker see the last push, wait out the results.
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
